### rtl/core/fsv_pkg.sv
// Shared types, constants and helper functions of the field stencil Verlet step unit.
`timescale 1ns / 1ps

package fsv_pkg;

    localparam int WORD_W     = 32;
    localparam int WIDE_W     = 64;
    localparam int DAMP_W     = 25;
    localparam int IDX_W      = 10;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;
    localparam int COEF_W     = 48;
    localparam int TSTEP_W    = 32;
    localparam int PCOUNT_W   = 11;
    localparam int SHIFT_W    = 7;

    localparam logic [DAMP_W-1:0]  DAMP_ONE    = 25'd16777216;
    localparam logic [WIDE_W-1:0]  LIM_MAG     = 64'h1000_0000_0000_0000;
    localparam logic [SHIFT_W-1:0] KICK_SHIFT  = 7'd33;
    localparam logic [SHIFT_W-1:0] DRIFT_SHIFT = 7'd32;
    localparam logic [SHIFT_W-1:0] DAMP_SHIFT  = 7'd24;

    localparam logic [COEF_W-1:0]   BETA_RESET   = 48'd1677722;
    localparam logic [COEF_W-1:0]   MASS2_RESET  = 48'd16777216;
    localparam logic [COEF_W-1:0]   KAPPA_RESET  = 48'd16777216;
    localparam logic [COEF_W-1:0]   MU_RESET     = 48'hFFFF_EC00_0000;
    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DX_SQ     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DX_FOURTH = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA          = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS_SQUARED  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KAPPA         = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MU            = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT   = 4'd7;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_SAT   = 2'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_PRIME = 2'd1,
        ACT_STEP  = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic                 start;
        logic                 is_div;
        wide_t                a;
        wide_t                b;
        logic [SHIFT_W-1:0]   shift;
    } math_req_t;

    typedef struct packed {
        logic  done;
        logic  sat;
        wide_t result;
    } math_rsp_t;

    function automatic logic signed [WORD_W-1:0] sat32_val(wide_t v);
        logic signed [WORD_W-1:0] r;
        if (v > wide_t'(64'sd2147483647)) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -wide_t'(64'sd2147483648)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic sat32_ovf(wide_t v);
        return (v > wide_t'(64'sd2147483647)) || (v < -wide_t'(64'sd2147483648));
    endfunction

endpackage

### rtl/core/fsv_if.sv
// Channel interfaces of the field stencil Verlet step unit: command, response, configuration.
`timescale 1ns / 1ps

interface fsv_cmd_if import fsv_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ACTION_W-1:0]      action;
    logic [IDX_W-1:0]         point_index;
    logic signed [WORD_W-1:0] phi_value;
    logic signed [WORD_W-1:0] velocity_value;
    logic [DAMP_W-1:0]        damp_value;

    modport source (output valid, action, point_index, phi_value, velocity_value, damp_value,
                    input ready);
    modport sink (input valid, action, point_index, phi_value, velocity_value, damp_value,
                  output ready);
endinterface

interface fsv_rsp_if import fsv_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] phi_out;
    logic signed [WORD_W-1:0] velocity_out;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, phi_out, velocity_out, status, input ready);
    modport sink (input valid, phi_out, velocity_out, status, output ready);
endinterface

interface fsv_cfg_if import fsv_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/field_stencil_verlet_step_unit.sv
// Top level: grid stores, pass sequencer and stencil evaluation of the Verlet step unit.
// Load and read: the command moves the sequencer to its output state, which registers the
// response once the response slot is free and then returns to idle for the next command.
// Prime: clears the edge points and fills the window, then evaluates each interior point on
// the one shared multiply and divide unit (eleven products and one quotient). Step: the same
// evaluation plus the two kicks and the drift over the interior points, and damping of every point.
// Reset clears control state and sets the registers to their defaults; the stores keep
// their contents and are undefined until loaded.
`timescale 1ns / 1ps

module field_stencil_verlet_step_unit import fsv_pkg::*; #(
    parameter int MAX_POINTS = 1024,
    parameter int FRAC_BITS  = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    fsv_cmd_if.sink   cmd,
    fsv_rsp_if.source rsp,
    fsv_cfg_if.sink   cfg
);

    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int CMPW = (CW > PCOUNT_W) ? CW : PCOUNT_W;
    localparam logic [CMPW-1:0]    N_MIN   = CMPW'(5);
    localparam logic [CMPW-1:0]    N_MAX   = CMPW'(MAX_POINTS);
    localparam logic [SHIFT_W-1:0] F_SHIFT = SHIFT_W'(FRAC_BITS);
    localparam wide_t              ONE     = wide_t'(64'sd1) <<< FRAC_BITS;
    localparam logic [3:0]         UOP_LAST = 4'd12;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b00000001,
        ST_ZERO    = 8'b00000010,
        ST_AC_RD   = 8'b00000100,
        ST_AC_WAIT = 8'b00001000,
        ST_AC_CALC = 8'b00010000,
        ST_PT_RD   = 8'b00100000,
        ST_PT_CALC = 8'b01000000,
        ST_OUT     = 8'b10000000
    } state_t;

    typedef enum logic [3:0] {
        P_KICK1 = 4'b0001,
        P_DRIFT = 4'b0010,
        P_KICK2 = 4'b0100,
        P_DAMP  = 4'b1000
    } pass_t;

    logic [TSTEP_W-1:0]  time_step_reg;
    logic [COEF_W-1:0]   inv_dx_sq_reg;
    logic [COEF_W-1:0]   inv_dx_fourth_reg;
    logic [COEF_W-1:0]   beta_reg;
    logic [COEF_W-1:0]   mass2_reg;
    logic [COEF_W-1:0]   kappa_reg;
    logic [COEF_W-1:0]   mu_reg;
    logic [PCOUNT_W-1:0] pcount_reg;

    state_t          state_reg;
    pass_t           pass_reg;
    action_t         action_reg;
    logic            is_step_reg;
    logic            bad_reg;
    logic            sat_reg;
    logic [CW-1:0]   n_reg;
    logic [CW-1:0]   ptr_reg;
    logic [1:0]      zcnt_reg;
    logic [3:0]      uop_reg;
    logic            issued_reg;

    logic signed [WORD_W-1:0] win_reg [5];
    logic signed [WORD_W-1:0] vtmp_reg;
    wide_t lap_reg, bt_reg, mt_reg, p2_reg, p3_reg, p5_reg, den_reg, den2_reg, dv_reg;

    logic                     rsp_valid_reg;
    logic signed [WORD_W-1:0] rsp_phi_reg;
    logic signed [WORD_W-1:0] rsp_vel_reg;
    logic [STATUS_W-1:0]      rsp_status_reg;

    logic [CMPW-1:0] pc_ext;
    logic [CMPW-1:0] n_sel;
    logic [CW-1:0]   n_cur;
    logic [CMPW-1:0] idx_ext;
    logic            idx_bad;
    logic [AW-1:0]   idx_addr;
    logic [AW-1:0]   ptr_addr;
    logic [CW-1:0]   pass_last;
    logic            accept;
    action_t         cmd_action;
    logic            out_free;

    math_req_t math_req;
    math_rsp_t math_rsp;

    logic                     f_we, v_we, a_we, d_we;
    logic [AW-1:0]            f_waddr, v_waddr, a_waddr, d_waddr;
    logic signed [WORD_W-1:0] f_wdata, v_wdata, a_wdata;
    logic [DAMP_W-1:0]        d_wdata;
    logic                     f_re, v_re, a_re, d_re;
    logic [AW-1:0]            raddr;
    logic [WORD_W-1:0]        f_rdata, v_rdata, a_rdata;
    logic [DAMP_W-1:0]        d_rdata;

    wide_t p_w, w0, w1, w3, w4, lapraw, braw, mu64, mu3;
    wide_t f_ext, v_ext, a_ext, kick_sum, drift_sum, acc_sum;
    logic  pt_last_uop;
    logic  pt_write;
    logic  ac_write;
    logic  load_ok;
    logic  load_clamp;
    logic  sat_event;

    always_comb
    begin
        pc_ext   = CMPW'(pcount_reg);
        if (pc_ext < N_MIN)
        begin
            n_sel = N_MIN;
        end
        else if (pc_ext > N_MAX)
        begin
            n_sel = N_MAX;
        end
        else
        begin
            n_sel = pc_ext;
        end
        n_cur      = n_sel[CW-1:0];
        idx_ext    = CMPW'(cmd.point_index);
        idx_bad    = idx_ext >= CMPW'(n_cur);
        idx_addr   = idx_ext[AW-1:0];
        ptr_addr   = ptr_reg[AW-1:0];
        pass_last  = (pass_reg == P_DAMP) ? (n_reg - CW'(1)) : (n_reg - CW'(3));
        accept     = cmd.valid && (state_reg == ST_IDLE);
        cmd_action = action_t'(cmd.action);
        out_free   = !rsp_valid_reg || rsp.ready;
        load_ok    = accept && (cmd_action == ACT_LOAD) && !idx_bad;
        load_clamp = load_ok && (cmd.damp_value > DAMP_ONE);
    end

    always_comb
    begin
        p_w    = wide_t'(win_reg[2]);
        w0     = wide_t'(win_reg[0]);
        w1     = wide_t'(win_reg[1]);
        w3     = wide_t'(win_reg[3]);
        w4     = wide_t'(win_reg[4]);
        lapraw = w3 + w1 - (p_w <<< 1);
        braw   = w0 + w4 + (p_w <<< 2) + (p_w <<< 1) - ((w1 + w3) <<< 2);
        mu64   = wide_t'(signed'(mu_reg));
        mu3    = (mu64 <<< 1) + mu64;
        f_ext  = wide_t'(signed'(f_rdata));
        v_ext  = wide_t'(signed'(v_rdata));
        a_ext  = wide_t'(signed'(a_rdata));
        kick_sum  = v_ext + math_rsp.result;
        drift_sum = f_ext + math_rsp.result;
        acc_sum   = lap_reg - bt_reg - mt_reg - dv_reg;
        pt_last_uop = (pass_reg != P_DAMP) || (uop_reg == 4'd1);
        pt_write    = (state_reg == ST_PT_CALC) && math_rsp.done && pt_last_uop;
        ac_write    = (state_reg == ST_AC_CALC) && (uop_reg == UOP_LAST);
    end

    always_comb
    begin
        math_req.start  = 1'b0;
        math_req.is_div = 1'b0;
        math_req.a      = '0;
        math_req.b      = '0;
        math_req.shift  = F_SHIFT;
        if (state_reg == ST_AC_CALC)
        begin
            math_req.start = !issued_reg && (uop_reg != UOP_LAST);
            unique case (uop_reg)
                4'd0:
                begin
                    math_req.a = lapraw;
                    math_req.b = wide_t'(inv_dx_sq_reg);
                end
                4'd1:
                begin
                    math_req.a = braw;
                    math_req.b = wide_t'(inv_dx_fourth_reg);
                end
                4'd2:
                begin
                    math_req.a = bt_reg;
                    math_req.b = wide_t'(beta_reg);
                end
                4'd3:
                begin
                    math_req.a = p_w;
                    math_req.b = wide_t'(mass2_reg);
                end
                4'd4:
                begin
                    math_req.a = p_w;
                    math_req.b = p_w;
                end
                4'd5:
                begin
                    math_req.a = p2_reg;
                    math_req.b = p_w;
                end
                4'd6:
                begin
                    math_req.a = p3_reg;
                    math_req.b = p2_reg;
                end
                4'd7:
                begin
                    math_req.a = p3_reg;
                    math_req.b = p3_reg;
                end
                4'd8:
                begin
                    math_req.a = wide_t'(kappa_reg);
                    math_req.b = den_reg;
                end
                4'd9:
                begin
                    math_req.a = den_reg;
                    math_req.b = den_reg;
                end
                4'd10:
                begin
                    math_req.a = mu3;
                    math_req.b = p5_reg;
                end
                4'd11:
                begin
                    math_req.is_div = 1'b1;
                    math_req.a      = dv_reg;
                    math_req.b      = den2_reg;
                end
                default:
                begin
                    math_req.a = '0;
                end
            endcase
        end
        else if (state_reg == ST_PT_CALC)
        begin
            math_req.start = !issued_reg;
            unique case (pass_reg)
                P_KICK1, P_KICK2:
                begin
                    math_req.a     = a_ext;
                    math_req.b     = wide_t'(time_step_reg);
                    math_req.shift = KICK_SHIFT;
                end
                P_DRIFT:
                begin
                    math_req.a     = v_ext;
                    math_req.b     = wide_t'(time_step_reg);
                    math_req.shift = DRIFT_SHIFT;
                end
                default:
                begin
                    math_req.a     = (uop_reg == 4'd0) ? v_ext : f_ext;
                    math_req.b     = wide_t'(d_rdata);
                    math_req.shift = DAMP_SHIFT;
                end
            endcase
        end
    end

    always_comb
    begin
        raddr = (state_reg == ST_IDLE) ? idx_addr : ptr_addr;
        f_re  = accept || (state_reg == ST_AC_RD) || (state_reg == ST_PT_RD);
        v_re  = accept || (state_reg == ST_PT_RD);
        a_re  = (state_reg == ST_PT_RD);
        d_re  = (state_reg == ST_PT_RD);

        f_we    = load_ok || (pt_write && ((pass_reg == P_DRIFT) || (pass_reg == P_DAMP)));
        f_waddr = (state_reg == ST_IDLE) ? idx_addr : ptr_addr;
        if (state_reg == ST_IDLE)
        begin
            f_wdata = cmd.phi_value;
        end
        else if (pass_reg == P_DRIFT)
        begin
            f_wdata = sat32_val(drift_sum);
        end
        else
        begin
            f_wdata = math_rsp.result[WORD_W-1:0];
        end

        v_we    = load_ok || (pt_write && (pass_reg != P_DRIFT));
        v_waddr = (state_reg == ST_IDLE) ? idx_addr : ptr_addr;
        if (state_reg == ST_IDLE)
        begin
            v_wdata = cmd.velocity_value;
        end
        else if (pass_reg == P_DAMP)
        begin
            v_wdata = vtmp_reg;
        end
        else
        begin
            v_wdata = sat32_val(kick_sum);
        end

        a_we = (state_reg == ST_ZERO) || ac_write;
        if (state_reg == ST_ZERO)
        begin
            a_wdata = '0;
            unique case (zcnt_reg)
                2'd0:    a_waddr = AW'(0);
                2'd1:    a_waddr = AW'(1);
                2'd2:    a_waddr = AW'(n_reg - CW'(2));
                default: a_waddr = AW'(n_reg - CW'(1));
            endcase
        end
        else
        begin
            a_wdata = sat32_val(acc_sum);
            a_waddr = AW'(ptr_reg - CW'(2));
        end

        d_we    = load_ok;
        d_waddr = idx_addr;
        d_wdata = load_clamp ? DAMP_ONE : cmd.damp_value;

        sat_event = load_clamp || (math_rsp.done && math_rsp.sat) || ac_write && sat32_ovf(acc_sum)
                    || (pt_write && (pass_reg == P_DRIFT) && sat32_ovf(drift_sum))
                    || (pt_write && ((pass_reg == P_KICK1) || (pass_reg == P_KICK2))
                        && sat32_ovf(kick_sum));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg     <= '0;
            inv_dx_sq_reg     <= '0;
            inv_dx_fourth_reg <= '0;
            beta_reg          <= BETA_RESET;
            mass2_reg         <= MASS2_RESET;
            kappa_reg         <= KAPPA_RESET;
            mu_reg            <= MU_RESET;
            pcount_reg        <= PCOUNT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TIME_STEP:     time_step_reg     <= cfg.data[TSTEP_W-1:0];
                CFG_INV_DX_SQ:     inv_dx_sq_reg     <= cfg.data[COEF_W-1:0];
                CFG_INV_DX_FOURTH: inv_dx_fourth_reg <= cfg.data[COEF_W-1:0];
                CFG_BETA:          beta_reg          <= cfg.data[COEF_W-1:0];
                CFG_MASS_SQUARED:  mass2_reg         <= cfg.data[COEF_W-1:0];
                CFG_KAPPA:         kappa_reg         <= cfg.data[COEF_W-1:0];
                CFG_MU:            mu_reg            <= cfg.data[COEF_W-1:0];
                CFG_POINT_COUNT:   pcount_reg        <= cfg.data[PCOUNT_W-1:0];
                default:           pcount_reg        <= pcount_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= P_KICK1;
            action_reg    <= ACT_LOAD;
            is_step_reg   <= 1'b0;
            bad_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            n_reg         <= '0;
            ptr_reg       <= '0;
            zcnt_reg      <= '0;
            uop_reg       <= '0;
            issued_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (sat_event)
            begin
                sat_reg <= 1'b1;
            end
            if (math_req.start)
            begin
                issued_reg <= 1'b1;
            end
            if ((state_reg == ST_OUT) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        action_reg <= cmd_action;
                        n_reg      <= n_cur;
                        sat_reg    <= load_clamp;
                        bad_reg    <= idx_bad && ((cmd_action == ACT_LOAD)
                                                  || (cmd_action == ACT_READ));
                        unique case (cmd_action)
                            ACT_PRIME:
                            begin
                                is_step_reg <= 1'b0;
                                zcnt_reg    <= '0;
                                state_reg   <= ST_ZERO;
                            end
                            ACT_STEP:
                            begin
                                is_step_reg <= 1'b1;
                                pass_reg    <= P_KICK1;
                                ptr_reg     <= CW'(2);
                                uop_reg     <= '0;
                                state_reg   <= ST_PT_RD;
                            end
                            default:
                            begin
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_ZERO:
                begin
                    zcnt_reg <= zcnt_reg + 2'd1;
                    if (zcnt_reg == 2'd3)
                    begin
                        ptr_reg   <= '0;
                        state_reg <= ST_AC_RD;
                    end
                end
                ST_AC_RD:
                begin
                    state_reg <= ST_AC_WAIT;
                end
                ST_AC_WAIT:
                begin
                    win_reg[0] <= win_reg[1];
                    win_reg[1] <= win_reg[2];
                    win_reg[2] <= win_reg[3];
                    win_reg[3] <= win_reg[4];
                    win_reg[4] <= f_rdata;
                    if (ptr_reg < CW'(4))
                    begin
                        ptr_reg   <= ptr_reg + CW'(1);
                        state_reg <= ST_AC_RD;
                    end
                    else
                    begin
                        uop_reg   <= '0;
                        state_reg <= ST_AC_CALC;
                    end
                end
                ST_AC_CALC:
                begin
                    if (math_rsp.done)
                    begin
                        issued_reg <= 1'b0;
                        uop_reg    <= uop_reg + 4'd1;
                        unique case (uop_reg)
                            4'd0:    lap_reg  <= math_rsp.result;
                            4'd1:    bt_reg   <= math_rsp.result;
                            4'd2:    bt_reg   <= math_rsp.result;
                            4'd3:    mt_reg   <= math_rsp.result;
                            4'd4:    p2_reg   <= math_rsp.result;
                            4'd5:    p3_reg   <= math_rsp.result;
                            4'd6:    p5_reg   <= math_rsp.result;
                            4'd7:    den_reg  <= math_rsp.result;
                            4'd8:    den_reg  <= ONE + math_rsp.result;
                            4'd9:    den2_reg <= math_rsp.result;
                            default: dv_reg   <= math_rsp.result;
                        endcase
                    end
                    else if (uop_reg == UOP_LAST)
                    begin
                        if (ptr_reg == n_reg - CW'(1))
                        begin
                            if (is_step_reg)
                            begin
                                pass_reg  <= P_KICK2;
                                ptr_reg   <= CW'(2);
                                uop_reg   <= '0;
                                state_reg <= ST_PT_RD;
                            end
                            else
                            begin
                                state_reg <= ST_OUT;
                            end
                        end
                        else
                        begin
                            ptr_reg   <= ptr_reg + CW'(1);
                            state_reg <= ST_AC_RD;
                        end
                    end
                end
                ST_PT_RD:
                begin
                    uop_reg   <= '0;
                    state_reg <= ST_PT_CALC;
                end
                ST_PT_CALC:
                begin
                    if (math_rsp.done)
                    begin
                        issued_reg <= 1'b0;
                        if (!pt_last_uop)
                        begin
                            vtmp_reg <= math_rsp.result[WORD_W-1:0];
                            uop_reg  <= 4'd1;
                        end
                        else if (ptr_reg != pass_last)
                        begin
                            ptr_reg   <= ptr_reg + CW'(1);
                            state_reg <= ST_PT_RD;
                        end
                        else
                        begin
                            unique case (pass_reg)
                                P_KICK1:
                                begin
                                    pass_reg  <= P_DRIFT;
                                    ptr_reg   <= CW'(2);
                                    state_reg <= ST_PT_RD;
                                end
                                P_DRIFT:
                                begin
                                    zcnt_reg  <= '0;
                                    state_reg <= ST_ZERO;
                                end
                                P_KICK2:
                                begin
                                    pass_reg  <= P_DAMP;
                                    ptr_reg   <= '0;
                                    state_reg <= ST_PT_RD;
                                end
                                default:
                                begin
                                    state_reg <= ST_OUT;
                                end
                            endcase
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && out_free)
        begin
            if ((action_reg == ACT_READ) && !bad_reg)
            begin
                rsp_phi_reg <= f_rdata;
                rsp_vel_reg <= v_rdata;
            end
            else
            begin
                rsp_phi_reg <= '0;
                rsp_vel_reg <= '0;
            end
            if (bad_reg)
            begin
                rsp_status_reg <= STAT_RANGE;
            end
            else if (sat_reg)
            begin
                rsp_status_reg <= STAT_SAT;
            end
            else
            begin
                rsp_status_reg <= STAT_OK;
            end
        end
    end

    assign cmd.ready        = (state_reg == ST_IDLE);
    assign cfg.ready        = 1'b1;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.phi_out      = rsp_phi_reg;
    assign rsp.velocity_out = rsp_vel_reg;
    assign rsp.status       = rsp_status_reg;

    fsv_math #(
        .FRAC_BITS (FRAC_BITS)
    ) u_math (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (math_req),
        .rsp   (math_rsp)
    );

    fsv_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_field_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .re    (f_re),
        .raddr (raddr),
        .rdata (f_rdata)
    );

    fsv_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_velocity_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (v_re),
        .raddr (raddr),
        .rdata (v_rdata)
    );

    fsv_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_accel_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (a_re),
        .raddr (raddr),
        .rdata (a_rdata)
    );

    fsv_ram #(.WIDTH(DAMP_W), .DEPTH(MAX_POINTS)) u_damp_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .re    (d_re),
        .raddr (raddr),
        .rdata (d_rdata)
    );

endmodule

### rtl/core/fsv_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module fsv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/fsv_math.sv
// Shared multi-cycle unit for rounded, saturated fixed-point products and quotients.
`timescale 1ns / 1ps

module fsv_math import fsv_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    input  math_req_t req,
    output math_rsp_t rsp
);

    localparam int DIVW = WIDE_W + FRAC_BITS;
    localparam int CNTW = $clog2(DIVW + 1);

    typedef enum logic [5:0] {
        M_IDLE  = 6'b000001,
        M_MUL   = 6'b000010,
        M_ROUND = 6'b000100,
        M_MFIN  = 6'b001000,
        M_DIV   = 6'b010000,
        M_DFIN  = 6'b100000
    } mstate_t;

    mstate_t              state_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic [WIDE_W-1:0]    ua_reg;
    logic [WIDE_W-1:0]    ub_reg;
    logic                 neg_reg;
    logic [SHIFT_W-1:0]   sh_reg;
    logic [2*WIDE_W-1:0]  acc_reg;
    logic [DIVW-1:0]      quo_reg;
    logic [WIDE_W-1:0]    rem_reg;
    math_rsp_t            rsp_reg;

    logic [WIDE_W-1:0]    ua_in;
    logic [WIDE_W-1:0]    ub_in;
    logic [31:0]          a_half;
    logic [31:0]          b_half;
    logic [WIDE_W-1:0]    prod;
    logic [2*WIDE_W-1:0]  prod_sh;
    logic [2*WIDE_W-1:0]  m_full;
    logic [WIDE_W-1:0]    m_sat;
    logic                 m_ovf;
    logic [WIDE_W:0]      rem_sh;
    logic [WIDE_W:0]      d_ext;
    logic                 ge;
    logic [DIVW-1:0]      q_sat;
    logic                 q_ovf;

    always_comb
    begin
        ua_in   = req.a[WIDE_W-1] ? WIDE_W'(-req.a) : WIDE_W'(req.a);
        ub_in   = req.b[WIDE_W-1] ? WIDE_W'(-req.b) : WIDE_W'(req.b);
        a_half  = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        b_half  = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        prod    = WIDE_W'(a_half) * WIDE_W'(b_half);
        unique case (cnt_reg[1:0])
            2'b00:   prod_sh = (2*WIDE_W)'(prod);
            2'b11:   prod_sh = (2*WIDE_W)'(prod) << 64;
            default: prod_sh = (2*WIDE_W)'(prod) << 32;
        endcase
        m_full  = acc_reg >> sh_reg;
        m_ovf   = m_full > (2*WIDE_W)'(LIM_MAG);
        m_sat   = m_ovf ? LIM_MAG : m_full[WIDE_W-1:0];
        rem_sh  = {rem_reg, quo_reg[DIVW-1]};
        d_ext   = {1'b0, ub_reg};
        ge      = rem_sh >= d_ext;
        q_ovf   = quo_reg > DIVW'(LIM_MAG);
        q_sat   = q_ovf ? DIVW'(LIM_MAG) : quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= M_IDLE;
            cnt_reg      <= '0;
            rsp_reg.done <= 1'b0;
        end
        else
        begin
            rsp_reg.done <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (req.start)
                    begin
                        ua_reg  <= ua_in;
                        ub_reg  <= ub_in;
                        neg_reg <= req.a[WIDE_W-1] ^ req.b[WIDE_W-1];
                        sh_reg  <= req.shift;
                        acc_reg <= '0;
                        rem_reg <= '0;
                        quo_reg <= {ua_in, {FRAC_BITS{1'b0}}};
                        cnt_reg <= '0;
                        state_reg <= req.is_div ? M_DIV : M_MUL;
                    end
                end
                M_MUL:
                begin
                    acc_reg <= acc_reg + prod_sh;
                    cnt_reg <= cnt_reg + CNTW'(1);
                    if (cnt_reg[1:0] == 2'b11)
                    begin
                        state_reg <= M_ROUND;
                    end
                end
                M_ROUND:
                begin
                    acc_reg   <= acc_reg + ((2*WIDE_W)'(1) << (sh_reg - SHIFT_W'(1)));
                    state_reg <= M_MFIN;
                end
                M_MFIN:
                begin
                    rsp_reg.done   <= 1'b1;
                    rsp_reg.sat    <= m_ovf;
                    rsp_reg.result <= neg_reg ? -wide_t'(m_sat) : wide_t'(m_sat);
                    state_reg      <= M_IDLE;
                end
                M_DIV:
                begin
                    rem_reg <= ge ? WIDE_W'(rem_sh - d_ext) : rem_sh[WIDE_W-1:0];
                    quo_reg <= {quo_reg[DIVW-2:0], ge};
                    cnt_reg <= cnt_reg + CNTW'(1);
                    if (cnt_reg == CNTW'(DIVW - 1))
                    begin
                        state_reg <= M_DFIN;
                    end
                end
                M_DFIN:
                begin
                    rsp_reg.done   <= 1'b1;
                    rsp_reg.sat    <= q_ovf;
                    rsp_reg.result <= neg_reg ? -wide_t'(q_sat[WIDE_W-1:0])
                                              : wide_t'(q_sat[WIDE_W-1:0]);
                    state_reg      <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign rsp = rsp_reg;

endmodule

### tb/fsv_step_checker.sv
// Checker for the field stencil Verlet step unit: grid prediction and response comparison.
`timescale 1ns / 1ps

module fsv_step_checker import fsv_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    fsv_cmd_if   cmd,
    fsv_rsp_if   rsp,
    fsv_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);

    localparam int GRID = 1024;
    localparam int FRAC = 24;

    typedef struct {
        logic signed [WORD_W-1:0] phi;
        logic signed [WORD_W-1:0] vel;
        logic [STATUS_W-1:0]      status;
    } grid_reply_t;

    grid_reply_t reply_q[$];

    longint unsigned dt_r, inv_sq_r, inv_four_r, beta_r, mass_r, kappa_r;
    longint          mu_r;
    logic [PCOUNT_W-1:0] pcount_r;

    longint field_mem[GRID];
    longint vel_mem[GRID];
    longint acc_mem[GRID];
    longint damp_mem[GRID];
    bit     clipped;

    initial begin
        fail_count = 0;
        pending    = 0;
        for (int i = 0; i < GRID; i++) begin
            field_mem[i] = 0;
            vel_mem[i]   = 0;
            acc_mem[i]   = 0;
            damp_mem[i]  = 0;
        end
    end

    function automatic longint round_mul(longint a, longint b, int sh);
        logic [127:0]    p;
        logic [63:0]     ua, ub;
        longint unsigned m;
        bit              neg;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 64'(-a) : 64'(a);
        ub  = (b < 0) ? 64'(-b) : 64'(b);
        p   = {64'd0, ua} * {64'd0, ub};
        p   = (p + (128'd1 << (sh - 1))) >> sh;
        if (p > {64'd0, LIM_MAG}) begin
            clipped = 1'b1;
            m = LIM_MAG;
        end else begin
            m = p[63:0];
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint frac_div(longint num, longint d);
        logic [63:0] un, ud, q, r;
        un = (num < 0) ? 64'(-num) : 64'(num);
        ud = d;
        q  = un / ud;
        r  = un % ud;
        if (q > LIM_MAG) begin
            clipped = 1'b1;
            q = LIM_MAG;
        end else begin
            for (int k = 0; k < FRAC; k++) begin
                r = r << 1;
                q = q << 1;
                if (r >= ud) begin
                    r = r - ud;
                    q = q | 64'd1;
                end
                if (q > LIM_MAG) begin
                    clipped = 1'b1;
                    q = LIM_MAG;
                    break;
                end
            end
        end
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) begin
            clipped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clipped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic void eval_accel(int n);
        longint one, mu3, p, lap, braw, bih, bt, mt, p2, p3, p5, p6, den, den2, dv;
        one = longint'(1) << FRAC;
        mu3 = 3 * mu_r;
        for (int i = 2; i + 2 < n; i++) begin
            p    = field_mem[i];
            lap  = round_mul(field_mem[i+1] - 2 * p + field_mem[i-1], inv_sq_r, FRAC);
            braw = field_mem[i-2] - 4 * field_mem[i-1] + 6 * p
                   - 4 * field_mem[i+1] + field_mem[i+2];
            bih  = round_mul(braw, inv_four_r, FRAC);
            bt   = round_mul(bih, beta_r, FRAC);
            mt   = round_mul(p, mass_r, FRAC);
            p2   = round_mul(p, p, FRAC);
            p3   = round_mul(p2, p, FRAC);
            p5   = round_mul(p3, p2, FRAC);
            p6   = round_mul(p3, p3, FRAC);
            den  = one + round_mul(kappa_r, p6, FRAC);
            den2 = round_mul(den, den, FRAC);
            dv   = frac_div(round_mul(mu3, p5, FRAC), den2);
            acc_mem[i] = clip32(lap - bt - mt - dv);
        end
        acc_mem[0]   = 0;
        acc_mem[1]   = 0;
        acc_mem[n-2] = 0;
        acc_mem[n-1] = 0;
    endfunction

    function automatic void kick(int n);
        for (int i = 2; i + 2 < n; i++) begin
            vel_mem[i] = clip32(vel_mem[i] + round_mul(acc_mem[i], dt_r, KICK_SHIFT));
        end
    endfunction

    function automatic void verlet_step(int n);
        kick(n);
        for (int i = 2; i + 2 < n; i++) begin
            field_mem[i] = clip32(field_mem[i] + round_mul(vel_mem[i], dt_r, DRIFT_SHIFT));
        end
        eval_accel(n);
        kick(n);
        for (int i = 0; i < n; i++) begin
            vel_mem[i]   = round_mul(vel_mem[i], damp_mem[i], DAMP_SHIFT);
            field_mem[i] = round_mul(field_mem[i], damp_mem[i], DAMP_SHIFT);
        end
    endfunction

    function automatic grid_reply_t predict(action_t act, int idx, longint phi, longint vel,
                                            longint damp);
        grid_reply_t e;
        int n;
        n = (pcount_r < 5) ? 5 : ((pcount_r > GRID) ? GRID : int'(pcount_r));
        e.phi    = '0;
        e.vel    = '0;
        e.status = STAT_OK;
        clipped  = 1'b0;
        case (act)
            ACT_LOAD, ACT_READ: begin
                if (idx >= n) begin
                    e.status = STAT_RANGE;
                end else if (act == ACT_LOAD) begin
                    field_mem[idx] = phi;
                    vel_mem[idx]   = vel;
                    if (damp > longint'(DAMP_ONE)) begin
                        damp = DAMP_ONE;
                        clipped = 1'b1;
                    end
                    damp_mem[idx] = damp;
                end else begin
                    e.phi = field_mem[idx][WORD_W-1:0];
                    e.vel = vel_mem[idx][WORD_W-1:0];
                end
            end
            ACT_PRIME: eval_accel(n);
            default:   verlet_step(n);
        endcase
        if (e.status == STAT_OK && clipped) e.status = STAT_SAT;
        return e;
    endfunction

    always @(posedge clk) begin
        grid_reply_t e;
        if (!rst_n) begin
            dt_r       = 0;
            inv_sq_r   = 0;
            inv_four_r = 0;
            beta_r     = BETA_RESET;
            mass_r     = MASS2_RESET;
            kappa_r    = KAPPA_RESET;
            mu_r       = $signed(MU_RESET);
            pcount_r   = PCOUNT_RESET;
            reply_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_TIME_STEP:     dt_r       = cfg.data[TSTEP_W-1:0];
                    CFG_INV_DX_SQ:     inv_sq_r   = cfg.data;
                    CFG_INV_DX_FOURTH: inv_four_r = cfg.data;
                    CFG_BETA:          beta_r     = cfg.data;
                    CFG_MASS_SQUARED:  mass_r     = cfg.data;
                    CFG_KAPPA:         kappa_r    = cfg.data;
                    CFG_MU:            mu_r       = $signed(cfg.data);
                    CFG_POINT_COUNT:   pcount_r   = cfg.data[PCOUNT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.valid && cmd.ready) begin
                reply_q.push_back(predict(action_t'(cmd.action), int'(cmd.point_index),
                                          longint'(cmd.phi_value),
                                          longint'(cmd.velocity_value),
                                          longint'(cmd.damp_value)));
            end
            if (rsp.valid && rsp.ready) begin
                if (reply_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected response beat at %0t", $realtime);
                end else begin
                    e = reply_q.pop_front();
                    if (rsp.phi_out !== e.phi || rsp.velocity_out !== e.vel
                        || rsp.status !== e.status) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch at %0t: phi %h/%h vel %h/%h status %0d/%0d",
                                     $realtime, e.phi, rsp.phi_out, e.vel,
                                     rsp.velocity_out, e.status, rsp.status);
                        end
                    end
                end
            end
        end
        pending = reply_q.size();
    end

endmodule

### tb/tb_top.sv
// Testbench top of the field stencil Verlet step unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import fsv_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd12;
    localparam logic [CFG_DATA_W-1:0] COEF_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam int ONE_Q24 = 16777216;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count, pending;
    int   sender_pct, recv_pct;
    bit   hold_rx;

    fsv_cmd_if cmd_ch();
    fsv_rsp_if rsp_ch();
    fsv_cfg_if cfg_ch();

    field_stencil_verlet_step_unit dut (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_ch), .rsp(rsp_ch), .cfg(cfg_ch)
    );

    fsv_step_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_ch), .rsp(rsp_ch), .cfg(cfg_ch),
        .fail_count(fail_count), .pending(pending)
    );

    always #5 clk = ~clk;

    initial begin
        #50ms;
        $display("field_stencil_verlet_step_unit test failed");
        $finish;
    end

    initial begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_rx) begin
                rsp_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_rx = 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_pct);
            end
        end
    end

    function automatic logic [31:0] small_val();
        return 32'(int'($urandom_range(0, 2 * ONE_Q24)) - ONE_Q24);
    endfunction

    task automatic issue(action_t act, logic [IDX_W-1:0] idx, logic [31:0] phi,
                         logic [31:0] vel, logic [DAMP_W-1:0] damp);
        int gap;
        gap = 0;
        if (sender_pct > 0) begin
            while ($urandom_range(0, 99) < sender_pct) gap++;
        end
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.action         <= act;
        cmd_ch.point_index    <= idx;
        cmd_ch.phi_value      <= phi;
        cmd_ch.velocity_value <= vel;
        cmd_ch.damp_value     <= damp;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
    endtask

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    task automatic set_config(logic [47:0] dt, logic [47:0] isq, logic [47:0] ifo,
                              logic [47:0] beta, logic [47:0] mass, logic [47:0] kappa,
                              logic [47:0] mu, logic [47:0] pc);
        write_reg(CFG_TIME_STEP, dt);
        write_reg(CFG_INV_DX_SQ, isq);
        write_reg(CFG_INV_DX_FOURTH, ifo);
        write_reg(CFG_BETA, beta);
        write_reg(CFG_MASS_SQUARED, mass);
        write_reg(CFG_KAPPA, kappa);
        write_reg(CFG_MU, mu);
        write_reg(CFG_POINT_COUNT, pc);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Every point in use gets loaded before the first prime or step reads the grid.
    task automatic fill_grid(int n);
        for (int i = 0; i < n; i++) begin
            issue(ACT_LOAD, IDX_W'(i), small_val(), small_val(),
                  DAMP_W'($urandom_range(15099494, ONE_Q24)));
        end
        issue(ACT_PRIME, '0, '0, '0, '0);
    endtask

    task automatic random_items(int count, int n);
        int r;
        logic [IDX_W-1:0] idx;
        for (int k = 0; k < count; k++) begin
            r   = $urandom_range(0, 99);
            idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, 1023))
                                              : IDX_W'($urandom_range(0, n - 1));
            if (r < 35) begin
                issue(ACT_LOAD, idx,
                      ($urandom_range(0, 9) == 0) ? 32'($urandom) : small_val(),
                      ($urandom_range(0, 9) == 0) ? 32'($urandom) : small_val(),
                      ($urandom_range(0, 9) == 0) ? DAMP_W'($urandom)
                                                  : DAMP_W'($urandom_range(15099494, ONE_Q24)));
            end else if (r < 65) begin
                issue(ACT_READ, idx, 32'($urandom), 32'($urandom), DAMP_W'($urandom));
            end else if (r < 80) begin
                issue(ACT_PRIME, idx, 32'($urandom), 32'($urandom), DAMP_W'($urandom));
            end else begin
                issue(ACT_STEP, idx, 32'($urandom), 32'($urandom), DAMP_W'($urandom));
            end
        end
    endtask

    initial begin
        rst_n          <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.action  <= ACT_LOAD;
        cmd_ch.point_index    <= '0;
        cmd_ch.phi_value      <= '0;
        cmd_ch.velocity_value <= '0;
        cmd_ch.damp_value     <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= CFG_TIME_STEP;
        cfg_ch.data    <= '0;
        sender_pct = 0;
        recv_pct   = 0;
        hold_rx    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_reg(CFG_UNUSED, COEF_MAX);
        set_config(48'h0147_AE14, 48'd67108864, 48'd268435456, 48'd1677722,
                   48'd16777216, 48'd16777216, 48'hFFFF_EC00_0000, 48'd8);
        fill_grid(8);
        issue(ACT_READ, 10'd3, '0, '0, '0);
        issue(ACT_STEP, '0, '0, '0, '0);
        issue(ACT_READ, 10'd2, '0, '0, '0);
        issue(ACT_READ, 10'd5, '0, '0, '0);
        issue(ACT_LOAD, 10'd1023, 32'h7FFF_FFFF, 32'h8000_0000, DAMP_ONE);
        issue(ACT_READ, 10'd1023, '0, '0, '0);
        issue(ACT_LOAD, 10'd7, small_val(), small_val(), 25'h1FF_FFFF);
        issue(ACT_LOAD, 10'd4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, DAMP_ONE);
        issue(ACT_LOAD, 10'd3, 32'h8000_0000, 32'h8000_0000, 25'd0);
        issue(ACT_STEP, '0, '0, '0, '0);
        issue(ACT_READ, 10'd3, '0, '0, '0);
        issue(ACT_READ, 10'd4, '0, '0, '0);
        settle();

        set_config(48'hFFFF_FFFF, 48'd16777216, 48'd16777216, 48'd0,
                   48'd33554432, 48'd0, 48'h7FFF_FFFF_FFFF, 48'd0);
        fill_grid(5);
        random_items(20, 5);
        settle();

        sender_pct = 77;
        set_config(48'h0A3D_70A4, 48'd100663296, 48'd50331648, 48'd8388608,
                   48'd4194304, 48'd33554432, 48'h8000_0000_0000, 48'd12);
        fill_grid(12);
        random_items(20, 12);
        settle();

        sender_pct = 0;
        recv_pct   = 77;
        set_config(48'h0147_AE14, COEF_MAX, COEF_MAX, COEF_MAX,
                   COEF_MAX, COEF_MAX, 48'hFFFF_EC00_0000, 48'd5);
        fill_grid(5);
        hold_rx = 1'b1;
        random_items(20, 5);
        settle();

        recv_pct = 0;
        set_config(48'h0001_0000, 48'd16777216, 48'd16777216, 48'd1677722,
                   48'd16777216, 48'd16777216, 48'hFFFF_EC00_0000, 48'd2047);
        issue(ACT_LOAD, 10'd0, small_val(), small_val(), DAMP_ONE);
        issue(ACT_LOAD, 10'd1023, small_val(), 32'h8000_0000, 25'd0);
        issue(ACT_READ, 10'd0, '0, '0, '0);
        issue(ACT_READ, 10'd1023, '0, '0, '0);
        settle();

        sender_pct = 8;
        recv_pct   = 8;
        set_config(48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd16777216,
                   48'hFFFF_FF00_0000, 48'd16);
        fill_grid(16);
        random_items(20, 16);
        settle();
        repeat (20) @(posedge clk);

        if (fail_count == 0) begin
            $display("field_stencil_verlet_step_unit test passed");
        end else begin
            $display("field_stencil_verlet_step_unit test failed");
        end
        $finish;
    end

endmodule

### field_stencil_verlet_step_unit.f
rtl/core/fsv_pkg.sv
rtl/core/fsv_if.sv
rtl/core/fsv_ram.sv
rtl/core/fsv_math.sv
rtl/core/field_stencil_verlet_step_unit.sv
tb/fsv_step_checker.sv
tb/tb_top.sv
